/* rtl/core/sgf_pkg.sv */
// Shared constants and types for the softened gravity force pipeline.
`default_nettype none

package sgf_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    typedef struct packed {
        logic [2:0] neg;
        logic [2:0] ovf;
        logic       zero;
    } side_t;

endpackage

`default_nettype wire

/* rtl/core/sgf_if.sv */
// Valid/ready channel interfaces for items, results and configuration.
`default_nettype none

interface sgf_item_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] pos_i_x;
    logic signed [W-1:0] pos_i_y;
    logic signed [W-1:0] pos_i_z;
    logic signed [W-1:0] pos_j_x;
    logic signed [W-1:0] pos_j_y;
    logic signed [W-1:0] pos_j_z;
    logic        [W-1:0] mass_j;

    modport source (output valid, pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z,
                    mass_j, input ready);
    modport sink   (input valid, pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z,
                    mass_j, output ready);
endinterface

interface sgf_result_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] force_x;
    logic signed [W-1:0] force_y;
    logic signed [W-1:0] force_z;

    modport source (output valid, force_x, force_y, force_z, input ready);
    modport sink   (input valid, force_x, force_y, force_z, output ready);
endinterface

interface sgf_cfg_if #(parameter int W = 32) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] softening_length;

    modport source (output valid, softening_length, input ready);
    modport sink   (input valid, softening_length, output ready);
endinterface

`default_nettype wire

/* rtl/core/sgf_sqrt_cell.sv */
// One digit cell of the pipelined integer square root.
`default_nettype none

module sgf_sqrt_cell #(
    parameter int SW  = 66,
    parameter int RW  = 33,
    parameter int NW  = 96,
    parameter int BIT = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  v_in,
    input  wire logic [SW-1:0]         rem_in,
    input  wire logic [RW-1:0]         res_in,
    input  wire logic [SW-1:0]         s_in,
    input  wire logic [2:0][NW-1:0]    num_in,
    input  wire sgf_pkg::side_t        side_in,
    output logic                       v_out,
    output logic [SW-1:0]              rem_out,
    output logic [RW-1:0]              res_out,
    output logic [SW-1:0]              s_out,
    output logic [2:0][NW-1:0]         num_out,
    output sgf_pkg::side_t             side_out
);

    logic [SW:0]   trial;
    logic          ge;
    logic [SW-1:0] rem_next;
    logic [RW-1:0] res_next;
    logic          v_reg;

    always_comb
    begin
        trial    = ((SW+1)'(res_in) << (BIT + 1)) | ((SW+1)'(1) << (2 * BIT));
        ge       = {1'b0, rem_in} >= trial;
        rem_next = ge ? (rem_in - trial[SW-1:0]) : rem_in;
        res_next = res_in;
        if (ge)
        begin
            res_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= rem_next;
            res_out  <= res_next;
            s_out    <= s_in;
            num_out  <= num_in;
            side_out <= side_in;
        end
    end

    assign v_out = v_reg;

endmodule

`default_nettype wire

/* rtl/core/sgf_div_cell.sv */
// One quotient-bit cell of the pipelined restoring divider, three axes wide.
`default_nettype none

module sgf_div_cell #(
    parameter int CW  = 131,
    parameter int DW  = 99,
    parameter int QW  = 32,
    parameter int BIT = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  v_in,
    input  wire logic [2:0][CW-1:0]    rem_in,
    input  wire logic [2:0][QW-1:0]    q_in,
    input  wire logic [DW-1:0]         den_in,
    input  wire sgf_pkg::side_t        side_in,
    output logic                       v_out,
    output logic [2:0][CW-1:0]         rem_out,
    output logic [2:0][QW-1:0]         q_out,
    output logic [DW-1:0]              den_out,
    output sgf_pkg::side_t             side_out
);

    logic [CW-1:0]         den_sh;
    logic [2:0][CW-1:0]    rem_next;
    logic [2:0][QW-1:0]    q_next;
    logic                  v_reg;

    always_comb
    begin
        den_sh = CW'(den_in) << BIT;
        for (int k = 0; k < 3; k++)
        begin
            q_next[k] = q_in[k];
            if (rem_in[k] >= den_sh)
            begin
                rem_next[k]    = rem_in[k] - den_sh;
                q_next[k][BIT] = 1'b1;
            end
            else
            begin
                rem_next[k] = rem_in[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= rem_next;
            q_out    <= q_next;
            den_out  <= den_in;
            side_out <= side_in;
        end
    end

    assign v_out = v_reg;

endmodule

`default_nettype wire

/* rtl/core/softened_gravity_force.sv */
// Stages in order: difference, product, sum, root cells, s4-s6, divider cells, output.
// Throughput: one pair per cycle; the square root and divider are cell chains of one
// digit per cycle, so a new pair enters every cycle while the skid entry is empty.
// A two-entry output (register plus skid) stalls the chain only when both are full.
// Reset: all valid bits clear; softening_length returns to 1.0.
`default_nettype none

module softened_gravity_force #(
    parameter int COORD_WIDTH = sgf_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = sgf_pkg::FRAC_BITS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    sgf_item_if.sink       items,
    sgf_result_if.source   results,
    sgf_cfg_if.sink        cfg
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2 * W + 2;
    localparam int RW = W + 1;
    localparam int NW = 2 * W + 2 * F;
    localparam int DW = SW + RW;
    localparam int CW = (NW > DW + W) ? NW : DW + W;

    logic en;
    logic [W-1:0] softening_length_reg;

    // stage 1: differences
    logic                 s1_v_reg;
    logic [2:0][W-1:0]    s1_mag_reg;
    logic [2:0]           s1_neg_reg;
    logic [W-1:0]         s1_mass_reg;
    logic [2:0][W-1:0]    pi_vec;
    logic [2:0][W-1:0]    pj_vec;
    logic [2:0][W-1:0]    mag_next;
    logic [2:0]           neg_next;
    logic signed [W:0]    diff;
    logic [W:0]           diff_neg;

    // stage 2: products
    logic                 s2_v_reg;
    logic [3:0][2*W-1:0]  s2_sq_reg;
    logic [2:0][2*W-1:0]  s2_prod_reg;
    logic                 s2_zero_reg;
    logic [2:0]           s2_neg_reg;

    // stage 3: sum
    logic                 s3_v_reg;
    logic [SW-1:0]        s3_s_reg;
    logic [2:0][NW-1:0]   s3_num_reg;
    sgf_pkg::side_t       s3_side_reg;

    // square root chain
    logic                 sq_v    [RW+1];
    logic [SW-1:0]        sq_rem  [RW+1];
    logic [RW-1:0]        sq_res  [RW+1];
    logic [SW-1:0]        sq_s    [RW+1];
    logic [2:0][NW-1:0]   sq_num  [RW+1];
    sgf_pkg::side_t       sq_side [RW+1];

    // stage 4/5/6: denominator and overflow check
    logic                 s4_v_reg;
    logic [2*RW-1:0]      s4_plo_reg;
    logic [2*RW-1:0]      s4_phi_reg;
    logic [2:0][NW-1:0]   s4_num_reg;
    sgf_pkg::side_t       s4_side_reg;
    logic                 s5_v_reg;
    logic [DW-1:0]        s5_den_reg;
    logic [2:0][NW-1:0]   s5_num_reg;
    sgf_pkg::side_t       s5_side_reg;
    logic                 s6_v_reg;
    logic [2:0][CW-1:0]   s6_rem_reg;
    logic [DW-1:0]        s6_den_reg;
    sgf_pkg::side_t       s6_side_reg;
    sgf_pkg::side_t       s6_side_next;

    // divider chain
    logic                 dv_v    [W+1];
    logic [2:0][CW-1:0]   dv_rem  [W+1];
    logic [2:0][W-1:0]    dv_q    [W+1];
    logic [DW-1:0]        dv_den  [W+1];
    sgf_pkg::side_t       dv_side [W+1];

    // output
    logic [2:0][W-1:0]    fin_val;
    logic                 out_v_reg;
    logic [2:0][W-1:0]    out_val_reg;
    logic                 skid_v_reg;
    logic [2:0][W-1:0]    skid_val_reg;

    assign en           = !skid_v_reg;
    assign items.ready  = en;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            softening_length_reg <= W'(1) << F;
        end
        else if (cfg.valid)
        begin
            softening_length_reg <= cfg.softening_length;
        end
    end

    always_comb
    begin
        pi_vec = {items.pos_i_z, items.pos_i_y, items.pos_i_x};
        pj_vec = {items.pos_j_z, items.pos_j_y, items.pos_j_x};
        diff     = '0;
        diff_neg = '0;
        for (int k = 0; k < 3; k++)
        begin
            diff        = $signed({pj_vec[k][W-1], pj_vec[k]})
                        - $signed({pi_vec[k][W-1], pi_vec[k]});
            diff_neg    = -diff;
            neg_next[k] = diff[W];
            mag_next[k] = diff[W] ? diff_neg[W-1:0] : diff[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= items.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= sq_v[RW];
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    always_comb
    begin
        s6_side_next = s5_side_reg;
        for (int k = 0; k < 3; k++)
        begin
            s6_side_next.ovf[k] = CW'(s5_num_reg[k]) >= (CW'(s5_den_reg) << W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg  <= mag_next;
            s1_neg_reg  <= neg_next;
            s1_mass_reg <= items.mass_j;

            for (int k = 0; k < 3; k++)
            begin
                s2_sq_reg[k]   <= (2*W)'(s1_mag_reg[k]) * (2*W)'(s1_mag_reg[k]);
                s2_prod_reg[k] <= (2*W)'(s1_mag_reg[k]) * (2*W)'(s1_mass_reg);
            end
            s2_sq_reg[3] <= (2*W)'(softening_length_reg) * (2*W)'(softening_length_reg);
            s2_zero_reg  <= (s1_mag_reg == '0) && (softening_length_reg == '0);
            s2_neg_reg   <= s1_neg_reg;

            s3_s_reg <= SW'(s2_sq_reg[0]) + SW'(s2_sq_reg[1])
                      + SW'(s2_sq_reg[2]) + SW'(s2_sq_reg[3]);
            for (int k = 0; k < 3; k++)
            begin
                s3_num_reg[k] <= NW'(s2_prod_reg[k]) << (2 * F);
            end
            s3_side_reg.neg  <= s2_neg_reg;
            s3_side_reg.ovf  <= '0;
            s3_side_reg.zero <= s2_zero_reg;

            s4_plo_reg  <= (2*RW)'(sq_s[RW][RW-1:0]) * (2*RW)'(sq_res[RW]);
            s4_phi_reg  <= (2*RW)'(sq_s[RW][SW-1:RW]) * (2*RW)'(sq_res[RW]);
            s4_num_reg  <= sq_num[RW];
            s4_side_reg <= sq_side[RW];

            s5_den_reg  <= (DW'(s4_phi_reg) << RW) + DW'(s4_plo_reg);
            s5_num_reg  <= s4_num_reg;
            s5_side_reg <= s4_side_reg;

            for (int k = 0; k < 3; k++)
            begin
                s6_rem_reg[k] <= CW'(s5_num_reg[k]);
            end
            s6_den_reg  <= s5_den_reg;
            s6_side_reg <= s6_side_next;
        end
    end

    assign sq_v[0]    = s3_v_reg;
    assign sq_rem[0]  = s3_s_reg;
    assign sq_res[0]  = '0;
    assign sq_s[0]    = s3_s_reg;
    assign sq_num[0]  = s3_num_reg;
    assign sq_side[0] = s3_side_reg;

    for (genvar g = 0; g < RW; g++)
    begin : g_sqrt
        sgf_sqrt_cell #(
            .SW  (SW),
            .RW  (RW),
            .NW  (NW),
            .BIT (RW - 1 - g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (sq_v[g]),
            .rem_in   (sq_rem[g]),
            .res_in   (sq_res[g]),
            .s_in     (sq_s[g]),
            .num_in   (sq_num[g]),
            .side_in  (sq_side[g]),
            .v_out    (sq_v[g+1]),
            .rem_out  (sq_rem[g+1]),
            .res_out  (sq_res[g+1]),
            .s_out    (sq_s[g+1]),
            .num_out  (sq_num[g+1]),
            .side_out (sq_side[g+1])
        );
    end

    assign dv_v[0]    = s6_v_reg;
    assign dv_rem[0]  = s6_rem_reg;
    assign dv_q[0]    = '0;
    assign dv_den[0]  = s6_den_reg;
    assign dv_side[0] = s6_side_reg;

    for (genvar g = 0; g < W; g++)
    begin : g_div
        sgf_div_cell #(
            .CW  (CW),
            .DW  (DW),
            .QW  (W),
            .BIT (W - 1 - g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (dv_v[g]),
            .rem_in   (dv_rem[g]),
            .q_in     (dv_q[g]),
            .den_in   (dv_den[g]),
            .side_in  (dv_side[g]),
            .v_out    (dv_v[g+1]),
            .rem_out  (dv_rem[g+1]),
            .q_out    (dv_q[g+1]),
            .den_out  (dv_den[g+1]),
            .side_out (dv_side[g+1])
        );
    end

    // sign, saturation and the zero-distance case
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (dv_side[W].zero)
            begin
                fin_val[k] = '0;
            end
            else if (!dv_side[W].neg[k])
            begin
                if (dv_side[W].ovf[k] || dv_q[W][k][W-1])
                begin
                    fin_val[k] = {1'b0, {(W-1){1'b1}}};
                end
                else
                begin
                    fin_val[k] = dv_q[W][k];
                end
            end
            else
            begin
                if (dv_side[W].ovf[k] || (dv_q[W][k] > {1'b1, {(W-1){1'b0}}}))
                begin
                    fin_val[k] = {1'b1, {(W-1){1'b0}}};
                end
                else
                begin
                    fin_val[k] = -dv_q[W][k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (results.ready || !out_v_reg)
        begin
            out_v_reg  <= skid_v_reg || dv_v[W];
            skid_v_reg <= 1'b0;
        end
        else if (en && dv_v[W])
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (results.ready || !out_v_reg)
        begin
            out_val_reg <= skid_v_reg ? skid_val_reg : fin_val;
        end
        else if (en)
        begin
            skid_val_reg <= fin_val;
        end
    end

    assign results.valid   = out_v_reg;
    assign results.force_x = out_val_reg[0];
    assign results.force_y = out_val_reg[1];
    assign results.force_z = out_val_reg[2];

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds a result while output register is empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !results.ready && dv_v[W]))
        else $error("skid filled without a stalled output");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && !results.ready) |=> skid_v_reg)
        else $error("skid result dropped while output stalled");

    a_no_entry_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |=> $stable(s1_v_reg))
        else $error("pipeline advanced while skid full");
`endif

endmodule

`default_nettype wire
